// ===== hw/rtl/nau_pkg.sv =====
// shared types, constants and tables for the activation unit
// used by nau_exp_cell, nau_div_cell and neural_activation_unit_core
package nau_pkg;

  localparam int DataW      = 16;
  localparam int FracW      = 11;
  localparam int AccW       = 30;
  localparam int KW         = 6;
  localparam int KMax       = 34;
  localparam int ExpTerms   = 13;
  localparam int DivSteps   = 31;
  localparam int RecipShift = 35;
  localparam int RoundShift = AccW - FracW;

  localparam logic [35:0] Ln2Q    = 36'd744261118;
  localparam logic [30:0] OneQ    = 31'h4000_0000;
  localparam logic [36:0] ExpZero = 37'd24 << AccW;

  typedef enum logic [2:0] {
    FnRelu    = 3'd0,
    FnReluDer = 3'd1,
    FnTanh    = 3'd2,
    FnTanhDer = 3'd3,
    FnSigm    = 3'd4,
    FnSigmDer = 3'd5
  } fn_e;

  typedef struct packed {
    logic [KW-1:0]    k;
    logic             zero;
    logic [29:0]      r;
    logic [30:0]      term;
    logic signed [32:0] sum;
    logic [DataW-1:0] raw;
  } exp_bus_t;

  typedef struct packed {
    logic [31:0]      rem;
    logic [30:0]      nlo;
    logic [30:0]      quo;
    logic [31:0]      den;
    logic [DataW-1:0] raw;
  } div_bus_t;

  // ceil(2^35 / n), exact truncating divide for operands below 2^31
  function automatic logic [35:0] recip(input logic [3:0] n);
    logic [35:0] m;
    case (n)
      4'd1:    m = 36'd34359738368;
      4'd2:    m = 36'd17179869184;
      4'd3:    m = 36'd11453246123;
      4'd4:    m = 36'd8589934592;
      4'd5:    m = 36'd6871947674;
      4'd6:    m = 36'd5726623062;
      4'd7:    m = 36'd4908534053;
      4'd8:    m = 36'd4294967296;
      4'd9:    m = 36'd3817748708;
      4'd10:   m = 36'd3435973837;
      4'd11:   m = 36'd3123612579;
      4'd12:   m = 36'd2863311531;
      4'd13:   m = 36'd2643056798;
      default: m = 36'd0;
    endcase
    return m;
  endfunction

  function automatic logic [35:0] kln2(input logic [KW-1:0] k);
    logic [71:0] p;
    p = {66'd0, k} * {36'd0, Ln2Q};
    return p[35:0];
  endfunction

endpackage

// ===== hw/rtl/nau_exp_cell.sv =====
// one taylor term of exp(-r): multiply by r, divide by the term index, accumulate
// depends on nau_pkg
module nau_exp_cell import nau_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic [3:0] n_i,
  input  logic     valid_i,
  input  exp_bus_t bus_i,
  output logic     valid_o,
  output exp_bus_t bus_o
);

  logic        v1_q, v2_q;
  exp_bus_t    b1_q, b2_q;
  logic [60:0] prod_q;
  logic [30:0] quo_q;
  logic [66:0] scaled;

  assign scaled = {36'd0, prod_q[60:30]} * {31'd0, recip(n_i)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_q   <= bus_i;
      prod_q <= {30'd0, bus_i.term} * {31'd0, bus_i.r};
      b2_q   <= b1_q;
      quo_q  <= scaled[RecipShift +: 31];
    end
  end

  always_comb begin
    bus_o      = b2_q;
    bus_o.term = quo_q;
    if (n_i[0]) begin
      bus_o.sum = b2_q.sum - $signed({2'b00, quo_q});
    end else begin
      bus_o.sum = b2_q.sum + $signed({2'b00, quo_q});
    end
  end

  assign valid_o = v2_q;

endmodule

// ===== hw/rtl/nau_div_cell.sv =====
// one restoring division step, one quotient bit per cell
// depends on nau_pkg
module nau_div_cell import nau_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  div_bus_t bus_i,
  output logic     valid_o,
  output div_bus_t bus_o
);

  logic        v_q;
  div_bus_t    b_q;
  logic [32:0] trial;
  logic        ge;
  logic [32:0] nxt;

  assign trial = {bus_i.rem, bus_i.nlo[30]};
  assign ge    = trial >= {1'b0, bus_i.den};
  assign nxt   = ge ? (trial - {1'b0, bus_i.den}) : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_q.rem <= nxt[31:0];
      b_q.nlo <= {bus_i.nlo[29:0], 1'b0};
      b_q.quo <= {bus_i.quo[29:0], ge};
      b_q.den <= bus_i.den;
      b_q.raw <= bus_i.raw;
    end
  end

  assign valid_o = v_q;
  assign bus_o   = b_q;

endmodule

// ===== hw/rtl/neural_activation_unit_core.sv =====
// activation unit top level: relu, tanh, sigmoid and their derivatives in Q5.11
// depends on nau_pkg, nau_exp_cell, nau_div_cell
//
// usage
//   input channel z_value_i / z_valid_i / z_ready_o carries one Q5.11 word
//   output channel y_value_o / y_valid_o / y_ready_i returns one Q5.11 word
//   cfg_we_i / cfg_wdata_i writes the function select, only while idle
// timing
//   one word per cycle sustained while the output is not stalled; each word passes
//   from acceptance to y_valid_o through the 13 two-stage taylor cells of the
//   exponential and the 31 single-bit cells of the restoring divider
// reset
//   empties the pipeline and selects relu
// stall
//   with y_valid_o high and y_ready_i low the whole pipeline holds and
//   z_ready_o drops; with the output register empty or being read, a new
//   word is taken every cycle
module neural_activation_unit_core import nau_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_wdata_i,
  input  logic [DataW-1:0] z_value_i,
  input  logic             z_valid_i,
  output logic             z_ready_o,
  output logic [DataW-1:0] y_value_o,
  output logic             y_valid_o,
  input  logic             y_ready_i
);

  fn_e fs_q;
  logic en;

  logic             v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, yv_q;
  logic [DataW-1:0] raw0_q, raw1_q, raw3_q, raw5_q;
  logic [36:0]      x1_q;
  logic [KW-1:0]    k1_q;
  logic             big1_q;
  exp_bus_t         e0_q;
  div_bus_t         d0_q;
  logic [30:0]      e3_q;
  logic [61:0]      prod_q;
  logic [30:0]      lin_q;
  logic [DataW-1:0] y_q;

  logic             is_tanh;
  logic [16:0]      mag0;
  logic [35:0]      a0;
  logic [36:0]      x0;
  logic [KMax-1:0]  ge0;
  logic [36:0]      rdiff;

  logic             ev [ExpTerms+1];
  exp_bus_t         eb [ExpTerms+1];
  logic             dv [DivSteps+1];
  div_bus_t         db [DivSteps+1];

  logic [31:0]      sclamp;
  logic [31:0]      eshift;
  logic [31:0]      den;
  logic [30:0]      hi;
  logic [60:0]      numer;

  logic [30:0]      sp, omsp, mula, mulb, lin;
  logic             neg5, pos5;
  logic [30:0]      q30;
  logic [31:0]      rnd;
  logic [DataW-1:0] mag5, y_d;

  assign en        = !yv_q || y_ready_i;
  assign z_ready_o = en;
  assign y_valid_o = yv_q;
  assign y_value_o = y_q;
  assign is_tanh   = (fs_q == FnTanh) || (fs_q == FnTanhDer);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= FnRelu;
    end else if (cfg_we_i) begin
      fs_q <= fn_e'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      yv_q <= 1'b0;
    end else if (en) begin
      v0_q <= z_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= ev[ExpTerms];
      v4_q <= v3_q;
      v5_q <= dv[DivSteps];
      yv_q <= v5_q;
    end
  end

  // magnitude, exponent argument and ln2 range reduction
  always_comb begin
    mag0 = raw0_q[DataW-1] ? (17'd0 - {raw0_q[DataW-1], raw0_q}) : {1'b0, raw0_q};
    a0   = {mag0, 19'd0};
    x0   = is_tanh ? {a0, 1'b0} : {1'b0, a0};
    for (int j = 0; j < KMax; j++) begin
      ge0[j] = x0 >= {1'b0, kln2(KW'(j + 1))};
    end
  end

  assign rdiff = x1_q - {1'b0, kln2(k1_q)};

  always_ff @(posedge clk_i) begin
    if (en) begin
      raw0_q    <= z_value_i;
      raw1_q    <= raw0_q;
      x1_q      <= x0;
      k1_q      <= KW'($countones(ge0));
      big1_q    <= x0 >= ExpZero;
      e0_q.k    <= k1_q;
      e0_q.zero <= big1_q;
      e0_q.r    <= rdiff[29:0];
      e0_q.term <= OneQ;
      e0_q.sum  <= $signed({2'b00, OneQ});
      e0_q.raw  <= raw1_q;
    end
  end

  assign ev[0] = v2_q;
  assign eb[0] = e0_q;

  for (genvar i = 0; i < ExpTerms; i++) begin : g_exp
    nau_exp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .n_i     (4'(i + 1)),
      .valid_i (ev[i]),
      .bus_i   (eb[i]),
      .valid_o (ev[i+1]),
      .bus_o   (eb[i+1])
    );
  end

  always_comb begin
    sclamp = eb[ExpTerms].sum[32] ? 32'd0 : eb[ExpTerms].sum[31:0];
    eshift = eb[ExpTerms].zero ? 32'd0 : (sclamp >> eb[ExpTerms].k);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e3_q   <= eshift[30:0];
      raw3_q <= eb[ExpTerms].raw;
    end
  end

  // numerator and divisor for the sigmoid or tanh quotient
  always_comb begin
    den   = {1'b0, OneQ} + {1'b0, e3_q};
    hi    = is_tanh ? (OneQ - e3_q) : OneQ;
    numer = {hi, 30'd0} + {30'd0, den[31:1]};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d0_q.rem <= {2'b00, numer[60:31]};
      d0_q.nlo <= numer[30:0];
      d0_q.quo <= '0;
      d0_q.den <= den;
      d0_q.raw <= raw3_q;
    end
  end

  assign dv[0] = v4_q;
  assign db[0] = d0_q;

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    nau_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[i]),
      .bus_i   (db[i]),
      .valid_o (dv[i+1]),
      .bus_o   (db[i+1])
    );
  end

  always_comb begin
    sp   = (db[DivSteps].quo > OneQ) ? OneQ : db[DivSteps].quo;
    omsp = OneQ - sp;
    mula = sp;
    mulb = (fs_q == FnTanhDer) ? sp : omsp;
    lin  = ((fs_q == FnSigm) && db[DivSteps].raw[DataW-1]) ? omsp : sp;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= {31'd0, mula} * {31'd0, mulb};
      lin_q  <= lin;
      raw5_q <= db[DivSteps].raw;
    end
  end

  // round to output format and select the function
  always_comb begin
    neg5 = raw5_q[DataW-1];
    pos5 = !neg5 && (raw5_q != '0);
    case (fs_q)
      FnTanhDer: q30 = OneQ - prod_q[60:30];
      FnSigmDer: q30 = prod_q[60:30];
      default:   q30 = lin_q;
    endcase
    rnd  = ({1'b0, q30} + (32'd1 << (RoundShift - 1))) >> RoundShift;
    mag5 = rnd[DataW-1:0];
    case (fs_q)
      FnRelu:    y_d = pos5 ? raw5_q : '0;
      FnReluDer: y_d = pos5 ? (DataW'(1) << FracW) : '0;
      FnTanh:    y_d = neg5 ? (DataW'(0) - mag5) : mag5;
      FnTanhDer: y_d = mag5;
      FnSigm:    y_d = mag5;
      FnSigmDer: y_d = mag5;
      default:   y_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      y_q <= y_d;
    end
  end

endmodule

// ===== verif/tb_neural_activation_unit_core.sv =====
// testbench for neural_activation_unit_core: streams Q5.11 words through every function select
// depends on nau_pkg and the rtl of the activation unit; results checked against a local predictor
`timescale 1ns / 100ps

module tb_neural_activation_unit_core;
  import nau_pkg::*;

  localparam longint unsigned Q30One = 64'd1 << 30;
  localparam longint unsigned Ln2Q30 = 64'd744261118;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 70;
  localparam int RandPerSetting = 66;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [2:0]       cfg_wdata_i;
  logic [DataW-1:0] z_value_i;
  logic             z_valid_i;
  logic             z_ready_o;
  logic [DataW-1:0] y_value_o;
  logic             y_valid_o;
  logic             y_ready_i;

  int send_idle;
  int recv_idle;
  int cycles;

  // exp(-x), x and result in Q.30
  function automatic longint unsigned exp_neg_q30(longint unsigned x);
    longint unsigned k;
    longint unsigned r;
    longint unsigned term;
    longint sum;
    if (x >= (64'd24 << 30)) return 0;
    k = x / Ln2Q30;
    r = x - k * Ln2Q30;
    term = Q30One;
    sum = longint'(Q30One);
    for (int n = 1; n <= 13; n++) begin
      term = ((term * r) >> 30) / longint'(n);
      if (n % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    return longint'(sum) >> k;
  endfunction

  function automatic longint unsigned round_q30(longint unsigned q);
    return (q + (64'd1 << 18)) >> 19;
  endfunction

  function automatic logic [DataW-1:0] sign_fit(bit neg, longint unsigned mag);
    longint unsigned m;
    m = mag;
    if (!neg && m > 32767) m = 32767;
    if (neg && m > 32768) m = 32768;
    return neg ? DataW'(-m) : DataW'(m);
  endfunction

  function automatic logic [DataW-1:0] activation(logic [2:0] fn, logic [DataW-1:0] z);
    bit neg;
    bit pos;
    longint unsigned mag;
    longint unsigned a;
    longint unsigned e;
    longint unsigned d;
    longint unsigned th;
    longint unsigned sp;
    neg = z[DataW-1];
    mag = neg ? (64'd65536 - z) : z;
    pos = !neg && z != 0;
    a = mag << 19;
    case (fn)
      FnRelu:    return pos ? z : '0;
      FnReluDer: return pos ? sign_fit(0, 64'd1 << 11) : '0;
      FnTanh, FnTanhDer: begin
        e = exp_neg_q30(a << 1);
        d = Q30One + e;
        th = (((Q30One - e) << 30) + (d >> 1)) / d;
        if (fn == FnTanh) return sign_fit(neg, round_q30(th));
        return sign_fit(0, round_q30(Q30One - ((th * th) >> 30)));
      end
      FnSigm, FnSigmDer: begin
        d = Q30One + exp_neg_q30(a);
        sp = ((Q30One << 30) + (d >> 1)) / d;
        if (sp > Q30One) sp = Q30One;
        if (fn == FnSigm) return sign_fit(0, round_q30(neg ? Q30One - sp : sp));
        return sign_fit(0, round_q30((sp * (Q30One - sp)) >> 30));
      end
      default:   return '0;
    endcase
  endfunction

  class activation_scoreboard;
    logic [2:0]       fn_sel;
    logic [DataW-1:0] expected_y[$];
    logic [DataW-1:0] sent_z[$];
    int               mismatches;
    int               checked;

    function void note_word(logic [DataW-1:0] z);
      expected_y.push_back(activation(fn_sel, z));
      sent_z.push_back(z);
    endfunction

    function void check_word(logic [DataW-1:0] y);
      logic [DataW-1:0] exp_y;
      logic [DataW-1:0] z;
      checked++;
      if (expected_y.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word y=%h", y);
        return;
      end
      exp_y = expected_y.pop_front();
      z = sent_z.pop_front();
      if (y !== exp_y) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch fn=%0d z=%h: expected y=%h, got y=%h", fn_sel, z, exp_y, y);
      end
    endfunction
  endclass

  activation_scoreboard sb;

  neural_activation_unit_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .z_value_i(z_value_i), .z_valid_i(z_valid_i), .z_ready_o(z_ready_o),
    .y_value_o(y_value_o), .y_valid_o(y_valid_o), .y_ready_i(y_ready_i)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // output side: check, then decide ready for the next edge
  initial begin
    y_ready_i = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (y_valid_o && y_ready_i) sb.check_word(y_value_o);
      y_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic push_word(logic [DataW-1:0] z);
    while ($urandom_range(99) < send_idle) begin
      z_valid_i <= 0;
      @(posedge clk_i);
    end
    z_valid_i <= 1;
    z_value_i <= z;
    do @(posedge clk_i); while (!z_ready_o);
    sb.note_word(z);
  endtask

  task automatic drain();
    z_valid_i <= 0;
    while (sb.expected_y.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_function(logic [2:0] fn);
    cfg_we_i <= 1;
    cfg_wdata_i <= fn;
    sb.fn_sel = fn;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  function automatic logic [DataW-1:0] rand_z();
    case ($urandom_range(3))
      0: return DataW'($urandom);
      1: return DataW'(int'($urandom_range(8192)) - 4096);
      2: return DataW'(int'($urandom_range(32768)) - 16384);
      default: return DataW'(int'($urandom_range(128)) - 64);
    endcase
  endfunction

  initial begin
    sb = new;
    sb.fn_sel = FnRelu;
    cycles = 0;
    send_idle = 17;
    recv_idle = 58;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_wdata_i = FnRelu;
    z_value_i = '0;
    z_valid_i = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 17 : (p == 1) ? 58 : 0;
      recv_idle = (p == 0) ? 58 : (p == 1) ? 17 : 0;
      for (int f = 0; f < 8; f++) begin
        drain();
        set_function(3'(f));
        if (p == 0) begin
          push_word(16'h7fff);
          push_word(16'h8000);
          push_word(16'h0000);
        end
        for (int i = 0; i < RandPerSetting; i++) begin
          if (p == 0 && f == FnTanh && i == RandPerSetting / 2) drain();
          push_word(rand_z());
        end
      end
    end
    drain();

    $display("ran %0d words over all eight function selects and three idling profiles",
             sb.checked);
    if (sb.mismatches == 0 && sb.expected_y.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d words outstanding", sb.mismatches, sb.expected_y.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== neural_activation_unit_core.f =====
hw/rtl/nau_pkg.sv
hw/rtl/nau_exp_cell.sv
hw/rtl/nau_div_cell.sv
hw/rtl/neural_activation_unit_core.sv
verif/tb_neural_activation_unit_core.sv
